// File: hw/rtl/sha1s_pkg.sv
package sha1s_pkg;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int unsigned NUM_WORDS   = 5;
   localparam int unsigned NUM_ROUNDS  = 80;
   localparam int unsigned PHASE_LEN   = 20;
   localparam int unsigned LEN_POS     = 56;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [31:0] K_PHASE0 = 32'h5a827999;
   localparam logic [31:0] K_PHASE1 = 32'h6ed9eba1;
   localparam logic [31:0] K_PHASE2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_PHASE3 = 32'hca62c1d6;

   localparam logic [NUM_WORDS-1:0][31:0] HASH_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] byte_val;
   } buf_ctrl_type;

   typedef struct packed {
      logic       load;
      logic       round;
      logic       fold;
      logic       reinit;
      logic [6:0] rnd;
   } core_ctrl_type;

endpackage

// File: hw/rtl/sha1s_msgbuf.sv
module sha1s_msgbuf
   import sha1s_pkg::*;
(
   input  logic         clock,
   input  buf_ctrl_type ctrl,
   output logic [31:0]  w_word
);

   // block bytes shift in at the bottom; during rounds the same register is
   // the sixteen-word schedule window, oldest word at the top
   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   logic [31:0]  mix;
   logic [31:0]  sched;

   function automatic logic [31:0] win(input logic [511:0] b, input int unsigned j);
      win = b[511 - 32*j -: 32];
   endfunction

   assign mix    = win(blk_ff, 13) ^ win(blk_ff, 8) ^ win(blk_ff, 2) ^ win(blk_ff, 0);
   assign sched  = {mix[30:0], mix[31]};
   assign w_word = blk_ff[511:480];

   always_comb begin
      blk_in = blk_ff;
      if (ctrl.shift_byte) begin
         blk_in = {blk_ff[503:0], ctrl.byte_val};
      end else if (ctrl.shift_word) begin
         blk_in = {blk_ff[479:0], sched};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

// File: hw/rtl/sha1s_core.sv
module sha1s_core
   import sha1s_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  core_ctrl_type                ctrl,
   input  logic [31:0]                  w_word,
   output logic [NUM_WORDS-1:0][31:0]   hash
);

   logic [NUM_WORDS-1:0][31:0] h_ff, h_in;
   logic [NUM_WORDS-1:0][31:0] v_ff, v_in;
   logic [31:0] a, b, c, d, e;
   logic [31:0] f, k, t;

   assign a = v_ff[0];
   assign b = v_ff[1];
   assign c = v_ff[2];
   assign d = v_ff[3];
   assign e = v_ff[4];

   // shared round unit
   always_comb begin
      if (ctrl.rnd < 7'(PHASE_LEN)) begin
         f = (b & c) | (~b & d);
         k = K_PHASE0;
      end else if (ctrl.rnd < 7'(2*PHASE_LEN)) begin
         f = b ^ c ^ d;
         k = K_PHASE1;
      end else if (ctrl.rnd < 7'(3*PHASE_LEN)) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_PHASE2;
      end else begin
         f = b ^ c ^ d;
         k = K_PHASE3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w_word;
   end

   always_comb begin
      v_in = v_ff;
      if (ctrl.load) begin
         v_in = h_ff;
      end else if (ctrl.round) begin
         v_in[0] = t;
         v_in[1] = a;
         v_in[2] = {b[1:0], b[31:2]};
         v_in[3] = c;
         v_in[4] = d;
      end
   end

   always_comb begin
      h_in = h_ff;
      if (ctrl.reinit) begin
         h_in = HASH_INIT;
      end else if (ctrl.fold) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= HASH_INIT;
      end else begin
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   assign hash = h_ff;

endmodule

// File: hw/rtl/sha1_stream_hasher.sv
// a message byte is taken while the hasher is idle; the byte that completes a block
// starts 80 rounds on the shared round unit and then one chaining fold
// finish: the block is padded out byte by byte and hashed; a length that
// spills pads and hashes a second block, then the five digest words leave
// no byte is taken while a 64-byte block is padded, run through the rounds or folded
// synchronous reset clears the sequencer and byte count and reloads the chaining words
module sha1_stream_hasher
   import sha1s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PAD   = 5'b00010,
      S_ROUND = 5'b00100,
      S_FOLD  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [60:0]   count_ff, count_in;
   logic [5:0]    fill_ff, fill_in;
   logic          marker_ff, marker_in;
   logic          lenblk_ff, lenblk_in;
   logic          padding_ff, padding_in;
   logic          final_ff, final_in;
   logic [6:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   buf_ctrl_type  buf_ctrl;
   core_ctrl_type core_ctrl;
   logic [31:0]   w_word;
   logic [NUM_WORDS-1:0][31:0] hash;

   logic [63:0]   bit_len;
   logic [2:0]    len_sel;
   logic [7:0]    len_byte;
   logic          req_take;

   assign bit_len  = {count_ff, 3'b000};
   assign len_sel  = 3'd7 - fill_ff[2:0];
   assign len_byte = bit_len[{len_sel, 3'b000} +: 8];
   assign req_take = req_valid && !req_stall;

   sha1s_msgbuf u_msgbuf (
      .clock  (clock),
      .ctrl   (buf_ctrl),
      .w_word (w_word)
   );

   sha1s_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (core_ctrl),
      .w_word (w_word),
      .hash   (hash)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      marker_in    = marker_ff;
      lenblk_in    = lenblk_ff;
      padding_in   = padding_ff;
      final_in     = final_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      buf_ctrl     = '0;
      core_ctrl    = '0;
      core_ctrl.rnd = rnd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.opcode == OP_FINISH) begin
                  marker_in  = 1'b1;
                  lenblk_in  = 1'b0;
                  padding_in = 1'b1;
                  state_in   = S_PAD;
               end else begin
                  buf_ctrl.shift_byte = 1'b1;
                  buf_ctrl.byte_val   = req_data.data_byte;
                  count_in = count_ff + 61'd1;
                  fill_in  = fill_ff + 6'd1;
                  if (fill_ff == 6'h3f) begin
                     core_ctrl.load = 1'b1;
                     rnd_in   = '0;
                     state_in = S_ROUND;
                  end
               end
            end
         end
         S_PAD: begin
            buf_ctrl.shift_byte = 1'b1;
            if (marker_ff) begin
               buf_ctrl.byte_val = PAD_MARKER;
               marker_in = 1'b0;
               lenblk_in = (fill_ff < 6'(LEN_POS));
            end else if (lenblk_ff && fill_ff >= 6'(LEN_POS)) begin
               buf_ctrl.byte_val = len_byte;
            end else begin
               buf_ctrl.byte_val = 8'h00;
            end
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'h3f) begin
               // only a block that carried the length closes the message
               final_in       = lenblk_ff && !marker_ff;
               core_ctrl.load = 1'b1;
               rnd_in   = '0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            core_ctrl.round     = 1'b1;
            buf_ctrl.shift_word = 1'b1;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(NUM_ROUNDS - 1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            core_ctrl.fold = 1'b1;
            if (!padding_ff) begin
               state_in = S_IDLE;
            end else if (final_ff) begin
               idx_in   = '0;
               state_in = S_EMIT;
            end else begin
               lenblk_in = 1'b1;
               state_in  = S_PAD;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = hash[idx_ff];
               rsp_data_in.word_index  = idx_ff;
               rsp_data_in.last        = (idx_ff == 3'(NUM_WORDS - 1));
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'(NUM_WORDS - 1)) begin
                  core_ctrl.reinit = 1'b1;
                  count_in   = '0;
                  padding_in = 1'b0;
                  final_in   = 1'b0;
                  idx_in     = '0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fill_ff      <= '0;
         marker_ff    <= 1'b0;
         lenblk_ff    <= 1'b0;
         padding_ff   <= 1'b0;
         final_ff     <= 1'b0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         marker_ff    <= marker_in;
         lenblk_ff    <= lenblk_in;
         padding_ff   <= padding_in;
         final_ff     <= final_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/sha1s_checker.sv
module sha1s_checker
   import sha1s_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.word_index == 3'(NUM_WORDS - 1))))
      else $error("last flag does not match word index");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.word_index < 3'(NUM_WORDS)))
      else $error("word index out of range");

   // finishing always starts padding, so no request is taken next cycle
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_FINISH |=> req_stall)
      else $error("request taken right after finish");

   // a word after the first follows the previous word by one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last ##1 rsp_valid
      |-> rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("digest words out of order");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);

// File: bench/tb_sha1_stream_hasher.sv
module tb_sha1_stream_hasher;
   timeunit 1ns;
   timeprecision 1ps;
   import sha1s_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 400;
   localparam int BLOCK_BYTES = 64;

   // running sha-1 of the accepted byte stream plus the digest words still owed
   class digest_tracker;
      logic [31:0] chain [NUM_WORDS];
      logic [7:0]  block [BLOCK_BYTES];
      logic [60:0] byte_count;
      rsp_type     pending_words [$];
      int          errors;
      int          words_checked;
      int          messages;
      int          bytes_hashed;

      function new();
         restart();
         errors        = 0;
         words_checked = 0;
         messages      = 0;
         bytes_hashed  = 0;
      endfunction

      function void restart();
         for (int i = 0; i < NUM_WORDS; i++) chain[i] = HASH_INIT[i];
         byte_count = '0;
      endfunction

      function void compress();
         logic [31:0] w [NUM_ROUNDS];
         logic [31:0] a, b, c, d, e, f, k, t, x;
         for (int i = 0; i < 16; i++)
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
         for (int i = 16; i < NUM_ROUNDS; i++) begin
            x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int i = 0; i < NUM_ROUNDS; i++) begin
            if (i < PHASE_LEN) begin
               f = (b & c) | (~b & d);
               k = K_PHASE0;
            end else if (i < 2 * PHASE_LEN) begin
               f = b ^ c ^ d;
               k = K_PHASE1;
            end else if (i < 3 * PHASE_LEN) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_PHASE2;
            end else begin
               f = b ^ c ^ d;
               k = K_PHASE3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void note_request(req_type item);
         int          pos;
         logic [63:0] bit_len;
         rsp_type     word;
         pos = int'(byte_count[5:0]);
         if (item.opcode == OP_ABSORB) begin
            block[pos] = item.data_byte;
            byte_count = byte_count + 61'd1;
            bytes_hashed++;
            if (pos == BLOCK_BYTES - 1) compress();
         end else begin
            bit_len    = {byte_count, 3'b000};
            block[pos] = PAD_MARKER;
            pos++;
            // no room left for the length field: pad out and spill into a second block
            if (pos > LEN_POS) begin
               while (pos < BLOCK_BYTES) begin
                  block[pos] = 8'h00;
                  pos++;
               end
               compress();
               pos = 0;
            end
            while (pos < LEN_POS) begin
               block[pos] = 8'h00;
               pos++;
            end
            for (int i = 0; i < 8; i++) block[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < NUM_WORDS; i++) begin
               word.digest_word = chain[i];
               word.word_index  = 3'(i);
               word.last        = (i == NUM_WORDS - 1);
               pending_words.push_back(word);
            end
            messages++;
            restart();
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: expected no digest word, got word %h index %0d last %b",
                     $time, got.digest_word, got.word_index, got.last);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (got.digest_word !== want.digest_word) begin
            $display("%0t: digest_word expected %h, got %h",
                     $time, want.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d, got %0d",
                     $time, want.word_index, got.word_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   digest_tracker tracker;
   int            cycle_count      = 0;
   int            items_sent       = 0;
   bit            sender_steady    = 1'b0;
   bit            hold_off_request = 1'b0;

   sha1_stream_hasher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_item(input logic opcode, input logic [7:0] value);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = {opcode, value};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.note_request(req_data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len, input logic [7:0] finish_byte);
      for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
      send_item(OP_FINISH, finish_byte);
   endtask

   initial begin
      int gap;
      bit steady;
      steady = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) steady = !steady;
         gap = steady ? 0 : $urandom_range(0, 19);
         if (hold_off_request) begin
            gap              = LONG_HOLD;
            hold_off_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_response(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      int len;
      int pick;
      int msg_index;
      tracker = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty message, with a stray byte on the finish that must be ignored
      send_item(OP_FINISH, 8'hff);
      send_item(OP_ABSORB, 8'h61);
      send_item(OP_ABSORB, 8'h62);
      send_item(OP_ABSORB, 8'h63);
      send_item(OP_FINISH, 8'h00);
      send_item(OP_ABSORB, 8'h00);
      send_item(OP_ABSORB, 8'hff);
      send_item(OP_ABSORB, 8'h80);
      send_item(OP_ABSORB, 8'h7f);
      send_item(OP_FINISH, 8'h5a);
      // back-to-back empty message checks the return to initial chaining values
      send_item(OP_FINISH, 8'h00);
      // length field no longer fits, so padding spills into a second block
      send_message(60, 8'h00);

      msg_index = 0;
      while (items_sent < 230 || tracker.messages < 12) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         pick          = $urandom_range(0, 9);
         if (pick < 6) len = $urandom_range(0, 12);
         else if (pick < 9) len = $urandom_range(50, 70);
         else len = $urandom_range(110, 130);
         if (msg_index == 3) begin
            // receiver sits on a digest while short messages keep coming
            hold_off_request = 1'b1;
            sender_steady    = 1'b1;
            send_message(3, 8'($urandom));
            send_message(5, 8'($urandom));
            send_message(0, 8'($urandom));
            sender_steady = 1'b0;
         end
         send_message(len, 8'($urandom));
         msg_index++;
      end
      req_valid = 1'b0;

      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("hashed %0d messages (%0d bytes, empty and two-block padding included)",
               tracker.messages, tracker.bytes_hashed);
      $display("checked %0d digest words under random gaps and one long result hold-off",
               tracker.words_checked);
      if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
